// File: sv/assert_macros.svh
// Assertion macros for the checker file.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define PTD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that stays live during reset as well.
`define PTD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/ptd_pkg.sv
// Package for the periodic task dispatcher: sizes, op codes, states, item types.
// No dependencies.
package ptd_pkg;

    localparam int TASK_SLOTS = 8;
    localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

    localparam logic [15:0] IDLE_NONE = 16'hFFFF;

    localparam logic [1:0] OP_REGISTER   = 2'd0;
    localparam logic [1:0] OP_SET_PERIOD = 2'd1;
    localparam logic [1:0] OP_DISPATCH   = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } ptd_state_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] start_delay;
        logic signed [15:0] new_period;
        logic [2:0]         slot_select;
        logic               run_flag;
        logic [15:0]        now;
    } ptd_cmd_t;

    typedef struct packed {
        logic        fired;
        logic [2:0]  fired_slot;
        logic        fired_flag;
        logic [15:0] idle_ticks;
        logic        accepted;
        logic [2:0]  assigned_slot;
    } ptd_result_t;

endpackage

// File: sv/periodic_task_dispatcher.sv
// Periodic task dispatcher top level: task table and dispatch sequencer.
// Depends on ptd_pkg.
//
// Usage:
//   Command channel: drive cmd and raise start; the item is taken at the
//   rising edge where start is high and busy is low.
//   Result channel: each item yields exactly one result, shown on result for
//   one cycle with done high. The receiver cannot stall; take it or lose it.
//
//   Register (op 0) and set-period (op 1) finish in the accepting edge: done
//   rises in the next cycle and busy stays low, so a new item may follow
//   immediately. An unknown op behaves the same and returns an all-zero result.
//   Dispatch (op 2) walks the table one slot per cycle through a single
//   subtract/add/compare unit: busy is high while the walk runs, and done
//   and the result are registered as the last slot is scanned. No new item
//   is taken until the slot walk is over.
//
//   Reset (rst_n low, asynchronous) clears the table, the free-slot count,
//   the last dispatch time and the sequencer; no clearing pass is needed.
module periodic_task_dispatcher (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  ptd_pkg::ptd_cmd_t    cmd,
    output logic                 busy,
    output logic                 done,
    output ptd_pkg::ptd_result_t result
);

    localparam int N = ptd_pkg::TASK_SLOTS;
    localparam int SW = ptd_pkg::SLOT_W;
    localparam int CW = ptd_pkg::CNT_W;

    // Task table
    logic [15:0] countdown_reg    [N];
    logic [15:0] countdown_next   [N];
    logic [15:0] period_reg       [N];
    logic [15:0] period_next      [N];
    logic [N-1:0] running_reg, running_next;
    logic [N-1:0] flag_reg, flag_next;
    logic [CW-1:0] free_reg, free_next;
    logic [15:0] last_time_reg, last_time_next;

    // Sequencer and scan accumulators
    ptd_pkg::ptd_state_t state_reg, state_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic [15:0]   elapsed_reg, elapsed_next;
    logic          hit_reg, hit_next;
    logic [SW-1:0] hit_slot_reg, hit_slot_next;
    logic          hit_flag_reg, hit_flag_next;
    logic [15:0]   best_reg, best_next;

    // Result register
    ptd_pkg::ptd_result_t result_reg, result_next;
    logic                 done_reg, done_next;

    logic take;
    logic scan_en;
    logic last_slot;
    logic [15:0] diff;
    logic expired;
    logic [SW-1:0] sel_idx;
    logic sel_ok;

    assign take      = start && !busy;
    assign last_slot = (idx_reg == SW'(N - 1));

    // Shared unit: one slot's countdown against the elapsed ticks
    assign diff    = countdown_reg[idx_reg] - elapsed_reg;
    assign expired = (diff == 16'd0) || diff[15];

    assign sel_idx = SW'(cmd.slot_select);
    assign sel_ok  = (32'(cmd.slot_select) < N) && running_reg[sel_idx];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptd_pkg::ST_IDLE:
            begin
                if (take && cmd.op == ptd_pkg::OP_DISPATCH)
                begin
                    state_next = ptd_pkg::ST_SCAN;
                end
            end
            ptd_pkg::ST_SCAN:
            begin
                if (last_slot)
                begin
                    state_next = ptd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ptd_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        busy    = 1'b0;
        scan_en = 1'b0;
        unique case (state_reg)
            ptd_pkg::ST_IDLE:
            begin
                busy    = 1'b0;
                scan_en = 1'b0;
            end
            ptd_pkg::ST_SCAN:
            begin
                busy    = 1'b1;
                scan_en = 1'b1;
            end
            default:
            begin
                busy    = 1'b0;
                scan_en = 1'b0;
            end
        endcase
    end

    // Datapath
    always_comb
    begin
        countdown_next = countdown_reg;
        period_next    = period_reg;
        running_next   = running_reg;
        flag_next      = flag_reg;
        free_next      = free_reg;
        last_time_next = last_time_reg;
        idx_next       = idx_reg;
        elapsed_next   = elapsed_reg;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        hit_flag_next  = hit_flag_reg;
        best_next      = best_reg;
        result_next    = result_reg;
        done_next      = 1'b0;

        if (take)
        begin
            case (cmd.op)
                ptd_pkg::OP_REGISTER:
                begin
                    result_next = '0;
                    done_next   = 1'b1;
                    if (32'(free_reg) < N)
                    begin
                        countdown_next[free_reg[SW-1:0]] = cmd.start_delay;
                        period_next[free_reg[SW-1:0]]    = cmd.new_period;
                        running_next[free_reg[SW-1:0]]   = 1'b1;
                        flag_next[free_reg[SW-1:0]]      = cmd.run_flag;
                        free_next                        = free_reg + CW'(1);
                        result_next.accepted             = 1'b1;
                        result_next.assigned_slot        = 3'(free_reg);
                    end
                end
                ptd_pkg::OP_SET_PERIOD:
                begin
                    result_next = '0;
                    done_next   = 1'b1;
                    if (sel_ok)
                    begin
                        period_next[sel_idx] = cmd.new_period;
                        result_next.accepted = 1'b1;
                    end
                end
                ptd_pkg::OP_DISPATCH:
                begin
                    // Latch elapsed time and clear the scan accumulators
                    elapsed_next   = cmd.now - last_time_reg;
                    last_time_next = cmd.now;
                    idx_next       = '0;
                    hit_next       = 1'b0;
                    hit_slot_next  = '0;
                    hit_flag_next  = 1'b0;
                    best_next      = ptd_pkg::IDLE_NONE;
                end
                default:
                begin
                    result_next = '0;
                    done_next   = 1'b1;
                end
            endcase
        end

        if (scan_en)
        begin
            if (running_reg[idx_reg])
            begin
                countdown_next[idx_reg] = diff;
                if (expired)
                begin
                    // First expired slot fires and reloads by its period
                    if (!hit_reg)
                    begin
                        hit_next                = 1'b1;
                        hit_slot_next           = idx_reg;
                        hit_flag_next           = flag_reg[idx_reg];
                        countdown_next[idx_reg] = diff + period_reg[idx_reg];
                    end
                    best_next = 16'd0;
                end
                else if (diff < best_reg)
                begin
                    best_next = diff;
                end
            end
            idx_next = idx_reg + SW'(1);
            if (last_slot)
            begin
                idx_next                  = '0;
                done_next                 = 1'b1;
                result_next               = '0;
                result_next.fired         = hit_next;
                result_next.fired_slot    = 3'(hit_slot_next);
                result_next.fired_flag    = hit_flag_next;
                result_next.idle_ticks    = best_next;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptd_pkg::ST_IDLE;
            idx_reg       <= '0;
            done_reg      <= 1'b0;
            running_reg   <= '0;
            flag_reg      <= '0;
            free_reg      <= '0;
            last_time_reg <= '0;
            hit_reg       <= 1'b0;
            for (int i = 0; i < N; i++)
            begin
                countdown_reg[i] <= '0;
                period_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            done_reg       <= done_next;
            running_reg    <= running_next;
            flag_reg       <= flag_next;
            free_reg       <= free_next;
            last_time_reg  <= last_time_next;
            hit_reg        <= hit_next;
            countdown_reg  <= countdown_next;
            period_reg     <= period_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        elapsed_reg  <= elapsed_next;
        hit_slot_reg <= hit_slot_next;
        hit_flag_reg <= hit_flag_next;
        best_reg     <= best_next;
        result_reg   <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: sv/ptd_checker.sv
// Port-level checker for the periodic task dispatcher, bound to the top level.
// Depends on ptd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptd_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input ptd_pkg::ptd_cmd_t    cmd,
    input logic                 busy,
    input logic                 done,
    input ptd_pkg::ptd_result_t result
);

    logic take;
    assign take = start && !busy;

    `PTD_ASSERT(a_fire_idle_zero, done && result.fired |-> result.idle_ticks == 16'd0, "fired item with nonzero idle time")
    `PTD_ASSERT(a_accept_clean, done && result.accepted |-> !result.fired && result.idle_ticks == 16'd0, "accepted item carries dispatch fields")
    `PTD_ASSERT(a_nofire_zero, done && !result.fired |-> result.fired_slot == 3'd0 && !result.fired_flag, "slot fields set without a firing task")
    `PTD_ASSERT(a_dispatch_busy, take && cmd.op == ptd_pkg::OP_DISPATCH |=> busy && !done, "dispatch item did not start a scan")
    `PTD_ASSERT(a_quick_done, take && cmd.op != ptd_pkg::OP_DISPATCH |=> done && !busy, "table item did not finish in one cycle")

endmodule

bind periodic_task_dispatcher ptd_checker u_ptd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// File: bench/tb.sv
// Self-checking testbench for periodic_task_dispatcher: directed and random command items,
// with results predicted by a scoreboard class that models the task table.
// Depends on ptd_pkg and periodic_task_dispatcher.
module tb;

    // Op code 3 has no function; the block must answer with an all-zero result.
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    localparam int CMD_BITS    = $bits(ptd_pkg::ptd_cmd_t);
    localparam int CYCLE_LIMIT = 400_000;
    localparam int PHASE_ITEMS = 475;

    // Model of the task table: predicts one result per accepted item and holds the
    // predictions until the block produces them.
    class task_table_scoreboard_t;
        bit [15:0]            remaining [ptd_pkg::TASK_SLOTS];
        bit [15:0]            reload    [ptd_pkg::TASK_SLOTS];
        bit                   running   [ptd_pkg::TASK_SLOTS];
        bit                   flag_of   [ptd_pkg::TASK_SLOTS];
        int                   used_slots;
        bit [15:0]            last_tick;
        ptd_pkg::ptd_result_t expected_results [$];
        int                   mismatches;
        int                   items_seen;
        int                   dispatches;
        int                   fires;
        int                   taken;
        int                   refused;
        int                   unknown_ops;

        function ptd_pkg::ptd_result_t predict_result(ptd_pkg::ptd_cmd_t c);
            ptd_pkg::ptd_result_t r;
            bit [15:0]            elapsed;
            int                   least;
            r = '0;
            case (c.op)
                ptd_pkg::OP_REGISTER:
                    if (used_slots < ptd_pkg::TASK_SLOTS)
                    begin
                        remaining[used_slots] = c.start_delay;
                        reload[used_slots]    = c.new_period;
                        running[used_slots]   = 1'b1;
                        flag_of[used_slots]   = c.run_flag;
                        r.accepted            = 1'b1;
                        r.assigned_slot       = 3'(used_slots);
                        used_slots++;
                        taken++;
                    end
                    else
                    begin
                        refused++;
                    end
                ptd_pkg::OP_SET_PERIOD:
                    if (int'(c.slot_select) < ptd_pkg::TASK_SLOTS && running[c.slot_select])
                    begin
                        reload[c.slot_select] = c.new_period;
                        r.accepted            = 1'b1;
                        taken++;
                    end
                    else
                    begin
                        refused++;
                    end
                ptd_pkg::OP_DISPATCH:
                begin
                    elapsed   = c.now - last_tick;
                    last_tick = c.now;
                    least     = 'hFFFF;
                    dispatches++;
                    for (int i = 0; i < ptd_pkg::TASK_SLOTS; i++)
                    begin
                        if (!running[i])
                            continue;
                        remaining[i] = remaining[i] - elapsed;
                        // Expired means zero or negative when read as signed.
                        if (remaining[i] == 16'd0 || remaining[i][15])
                        begin
                            if (!r.fired)
                            begin
                                r.fired      = 1'b1;
                                r.fired_slot = 3'(i);
                                r.fired_flag = flag_of[i];
                                remaining[i] = remaining[i] + reload[i];
                                fires++;
                            end
                            least = 0;
                        end
                        else if (int'(remaining[i]) < least)
                        begin
                            least = int'(remaining[i]);
                        end
                    end
                    r.idle_ticks = 16'(least);
                end
                default:
                    unknown_ops++;
            endcase
            return r;
        endfunction

        function void note_command(ptd_pkg::ptd_cmd_t c);
            items_seen++;
            expected_results.push_back(predict_result(c));
        endfunction

        task report(string what);
            $display("MISMATCH: %s", what);
            mismatches++;
        endtask

        task check_field(string name, int got, int want);
            if (got != want)
                report($sformatf("%s got %0d, expected %0d", name, got, want));
        endtask

        task check_result(ptd_pkg::ptd_result_t got);
            ptd_pkg::ptd_result_t want;
            if (expected_results.size() == 0)
            begin
                report($sformatf("result %h with no item outstanding", got));
                return;
            end
            want = expected_results.pop_front();
            check_field("fired",         got.fired,         want.fired);
            check_field("fired_slot",    got.fired_slot,    want.fired_slot);
            check_field("fired_flag",    got.fired_flag,    want.fired_flag);
            check_field("idle_ticks",    got.idle_ticks,    want.idle_ticks);
            check_field("accepted",      got.accepted,      want.accepted);
            check_field("assigned_slot", got.assigned_slot, want.assigned_slot);
        endtask

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    ptd_pkg::ptd_cmd_t    cmd;
    logic                 busy;
    logic                 done;
    ptd_pkg::ptd_result_t result;

    task_table_scoreboard_t table_model = new();
    bit [15:0]              tick;
    int                     cycles = 0;

    periodic_task_dispatcher dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    // Watch both channels at every rising edge. Values read here are the ones
    // present before this edge's updates, so acceptance and results are seen
    // exactly as the block sees them. Check before noting: a result never
    // belongs to an item taken at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                table_model.check_result(result);
            if (start && !busy)
                table_model.note_command(cmd);
        end
    end

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, table_model.pending());
            $display("** periodic_task_dispatcher: FAILED **");
            $finish;
        end
    end

    function automatic ptd_pkg::ptd_cmd_t directed(logic [1:0] op, logic [15:0] delay,
                                                   logic [15:0] period, logic [2:0] sel,
                                                   logic flag, logic [15:0] now_val);
        ptd_pkg::ptd_cmd_t c;
        c.op          = op;
        c.start_delay = delay;
        c.new_period  = period;
        c.slot_select = sel;
        c.run_flag    = flag;
        c.now         = now_val;
        return c;
    endfunction

    // Mostly dispatches with the tick moving forward in small steps, so countdowns
    // walk down and reload over and over; now and then jump the tick anywhere to
    // force wrapped elapsed times. Periods lean small and positive, with zero,
    // negatives and the extremes mixed in.
    function automatic ptd_pkg::ptd_cmd_t random_cmd();
        ptd_pkg::ptd_cmd_t c;
        int                pick;
        c.start_delay = 16'($urandom);
        c.slot_select = 3'($urandom);
        c.run_flag    = 1'($urandom);
        c.now         = 16'($urandom);
        case ($urandom_range(9))
            0:       c.new_period = 16'sh8000;
            1:       c.new_period = 16'sh7FFF;
            2:       c.new_period = 16'sd0;
            3:       c.new_period = -16'($urandom_range(1, 50));
            4:       c.new_period = 16'($urandom);
            default: c.new_period = 16'($urandom_range(1, 400));
        endcase
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            c.op = ptd_pkg::OP_DISPATCH;
            if ($urandom_range(9) == 0)
                tick = 16'($urandom);
            else
                tick = tick + 16'($urandom_range(0, 300));
            c.now = tick;
        end
        else if (pick < 85)
        begin
            c.op = ptd_pkg::OP_SET_PERIOD;
        end
        else if (pick < 95)
        begin
            c.op = ptd_pkg::OP_REGISTER;
        end
        else
        begin
            c.op = OP_UNKNOWN;
        end
        return c;
    endfunction

    // Hold the item on the command port until the block takes it.
    task automatic drive_item(input ptd_pkg::ptd_cmd_t c);
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drop start for a random number of cycles, pct percent chance per cycle,
    // and scramble the command bus meanwhile.
    task automatic idle_gap(input int pct);
        while (int'($urandom_range(99)) < pct)
        begin
            start <= 1'b0;
            cmd   <= ptd_pkg::ptd_cmd_t'(CMD_BITS'({$urandom, $urandom}));
            @(posedge clk);
        end
    endtask

    initial
    begin
        ptd_pkg::ptd_cmd_t directed_items [$];
        int                sender_idle [4];

        rst_n  = 1'b0;
        start  = 1'b0;
        cmd    = '0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: empty table, unused slot, unknown op, extreme delays and
        // periods, simultaneous expiry, zero elapsed, wrapped elapsed, full table.
        directed_items.push_back(directed(ptd_pkg::OP_DISPATCH,
                                          16'h1234, 16'h5678, 3'd5, 1'b1, 16'd0));
        directed_items.push_back(directed(ptd_pkg::OP_SET_PERIOD,
                                          16'h0000, 16'd10,   3'd0, 1'b0, 16'hFFFF));
        directed_items.push_back(directed(OP_UNKNOWN,
                                          16'hFFFF, 16'hFFFF, 3'd7, 1'b1, 16'hFFFF));
        directed_items.push_back(directed(ptd_pkg::OP_REGISTER,
                                          16'd0,    16'd1,    3'd7, 1'b1, 16'd0));
        directed_items.push_back(directed(ptd_pkg::OP_REGISTER,
                                          16'h7FFF, 16'h8000, 3'd0, 1'b0, 16'hAAAA));
        directed_items.push_back(directed(ptd_pkg::OP_REGISTER,
                                          16'h8000, 16'h7FFF, 3'd2, 1'b1, 16'h5555));
        directed_items.push_back(directed(ptd_pkg::OP_REGISTER,
                                          16'd100,  16'd100,  3'd0, 1'b0, 16'd0));
        directed_items.push_back(directed(ptd_pkg::OP_DISPATCH,
                                          16'h0000, 16'h0000, 3'd0, 1'b0, 16'd0));
        directed_items.push_back(directed(ptd_pkg::OP_DISPATCH,
                                          16'h0000, 16'h0000, 3'd0, 1'b0, 16'd0));
        directed_items.push_back(directed(ptd_pkg::OP_SET_PERIOD,
                                          16'h0000, 16'd0,    3'd3, 1'b1, 16'd0));
        directed_items.push_back(directed(ptd_pkg::OP_SET_PERIOD,
                                          16'h0000, 16'd5,    3'd7, 1'b0, 16'd0));
        directed_items.push_back(directed(ptd_pkg::OP_DISPATCH,
                                          16'h0000, 16'h0000, 3'd0, 1'b0, 16'hFFFF));
        directed_items.push_back(directed(ptd_pkg::OP_DISPATCH,
                                          16'h0000, 16'h0000, 3'd0, 1'b0, 16'd200));
        directed_items.push_back(directed(ptd_pkg::OP_REGISTER,
                                          16'd50,   16'hFFFF, 3'd1, 1'b1, 16'd0));
        directed_items.push_back(directed(ptd_pkg::OP_REGISTER,
                                          16'd1,    16'd3,    3'd4, 1'b0, 16'd0));
        directed_items.push_back(directed(ptd_pkg::OP_REGISTER,
                                          16'd400,  16'd7,    3'd6, 1'b1, 16'd0));
        directed_items.push_back(directed(ptd_pkg::OP_REGISTER,
                                          16'd20,   16'd20,   3'd2, 1'b0, 16'd0));
        directed_items.push_back(directed(ptd_pkg::OP_REGISTER,
                                          16'd5,    16'd5,    3'd3, 1'b1, 16'd0));
        directed_items.push_back(directed(ptd_pkg::OP_SET_PERIOD,
                                          16'h0000, 16'h8000, 3'd7, 1'b0, 16'd0));
        directed_items.push_back(directed(ptd_pkg::OP_DISPATCH,
                                          16'h0000, 16'h0000, 3'd0, 1'b0, 16'd210));
        directed_items.push_back(directed(ptd_pkg::OP_DISPATCH,
                                          16'h0000, 16'h0000, 3'd0, 1'b0, 16'd210));
        directed_items.push_back(directed(ptd_pkg::OP_DISPATCH,
                                          16'h0000, 16'h0000, 3'd0, 1'b0, 16'h8000));
        directed_items.push_back(directed(OP_UNKNOWN,
                                          16'h0000, 16'h0000, 3'd0, 1'b0, 16'd0));
        foreach (directed_items[k])
            drive_item(directed_items[k]);
        tick = 16'h8000;

        // Random phases: back to back, sender mostly idle, sender lightly idle,
        // then back to back again. The result side cannot stall.
        sender_idle = '{0, 80, 7, 0};
        foreach (sender_idle[p])
        begin
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                idle_gap(sender_idle[p]);
                drive_item(random_cmd());
            end
        end
        start <= 1'b0;
        @(posedge clk);

        // Drain outstanding results, then linger past one dispatch walk to catch
        // any stray result strobe.
        while (table_model.pending() != 0)
            @(posedge clk);
        repeat (ptd_pkg::TASK_SLOTS + 4)
            @(posedge clk);

        $display("Covered %0d items: %0d dispatches with %0d firing, %0d register or",
                 table_model.items_seen, table_model.dispatches, table_model.fires,
                 table_model.taken);
        $display("set-period items taken, %0d refused, %0d with an unknown op.",
                 table_model.refused, table_model.unknown_ops);
        if (table_model.mismatches == 0)
        begin
            $display("** periodic_task_dispatcher: PASSED **");
        end
        else
        begin
            $display("%0d mismatches", table_model.mismatches);
            $display("** periodic_task_dispatcher: FAILED **");
        end
        $finish;
    end
endmodule
